// ----- rtl/nfs_pkg.sv -----
// ----------------------------------------------------------------------------
// nfs_pkg
// Types and constants shared by the numeric field scanner modules.
// ----------------------------------------------------------------------------
package nfs_pkg;

    // Register indexes on the configuration port
    localparam logic [1:0] REG_BASE_MODE   = 2'd0;
    localparam logic [1:0] REG_MAX_WIDTH   = 2'd1;
    localparam logic [1:0] REG_RESULT_SIZE = 2'd2;

    // Register codes
    localparam logic [1:0] BASE_OCT  = 2'd1;
    localparam logic [1:0] BASE_HEX  = 2'd2;
    localparam logic [1:0] SIZE_LONG = 2'd2;

    localparam logic [1:0]  BASE_MODE_RESET   = 2'd0;
    localparam logic [1:0]  RESULT_SIZE_RESET = 2'd1;
    localparam logic [14:0] DEFAULT_WIDTH     = 15'd30000;

    // Character codes
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_NL      = 8'h0A;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_UC_A    = 8'h41;
    localparam logic [7:0] CH_UC_F    = 8'h46;
    localparam logic [7:0] CH_LC_A    = 8'h61;
    localparam logic [7:0] CH_LC_F    = 8'h66;
    localparam logic [7:0] UC_BIAS    = CH_UC_A - 8'd10;
    localparam logic [7:0] LC_BIAS    = CH_LC_A - 8'd10;

    // Queue between classifier and converter
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [7:0] char_code;
        logic       is_end;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] value;
        logic               assigned;
        logic               ended_by_eof;
        logic               char_consumed;
    } result_t;

    typedef enum logic [2:0] {
        KIND_END,
        KIND_SPACE,
        KIND_MINUS,
        KIND_PLUS,
        KIND_DIGIT,
        KIND_OTHER
    } char_kind_t;

    typedef struct packed {
        char_kind_t kind;
        logic [3:0] digit;
    } char_class_t;

    typedef enum logic {
        PH_SKIP,
        PH_DIGITS
    } phase_t;

    typedef struct packed {
        logic [1:0]  base_mode;
        logic [14:0] max_width;
        logic [1:0]  result_size;
    } cfg_t;

endpackage

// ----- rtl/nfs_front.sv -----
// ----------------------------------------------------------------------------
// nfs_front
// Accepts characters and classifies them into kind and digit value.
// ----------------------------------------------------------------------------
module nfs_front
    import nfs_pkg::*;
(
    input  logic        valid,
    output logic        stall,
    input  in_item_t    item,
    input  logic [1:0]  base_mode,
    input  logic        queue_full,
    output logic        push,
    output char_class_t push_data
);

    logic [7:0] c;
    logic       is_dec;
    logic       is_lc;
    logic       is_uc;
    logic       hex_mode;

    assign c        = item.char_code;
    assign hex_mode = (base_mode == BASE_HEX);
    assign is_dec   = (c >= CH_ZERO) && (c <= CH_NINE);
    assign is_lc    = hex_mode && (c >= CH_LC_A) && (c <= CH_LC_F);
    assign is_uc    = hex_mode && (c >= CH_UC_A) && (c <= CH_UC_F);

    assign stall = queue_full;
    assign push  = valid && !queue_full;

    always_comb
    begin
        push_data.digit = c[3:0];
        if (item.is_end)
        begin
            push_data.kind = KIND_END;
        end
        else if (c == CH_SPACE || c == CH_TAB || c == CH_NL)
        begin
            push_data.kind = KIND_SPACE;
        end
        else if (c == CH_MINUS)
        begin
            push_data.kind = KIND_MINUS;
        end
        else if (c == CH_PLUS)
        begin
            push_data.kind = KIND_PLUS;
        end
        else if (is_dec)
        begin
            push_data.kind = KIND_DIGIT;
        end
        else if (is_lc)
        begin
            push_data.kind  = KIND_DIGIT;
            push_data.digit = 4'(c - LC_BIAS);
        end
        else if (is_uc)
        begin
            push_data.kind  = KIND_DIGIT;
            push_data.digit = 4'(c - UC_BIAS);
        end
        else
        begin
            push_data.kind = KIND_OTHER;
        end
    end

endmodule

// ----- rtl/nfs_queue.sv -----
// ----------------------------------------------------------------------------
// nfs_queue
// Short queue of classified characters between front and back.
// ----------------------------------------------------------------------------
module nfs_queue
    import nfs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  char_class_t push_data,
    input  logic        pop,
    output char_class_t head,
    output logic        full,
    output logic        empty
);

    char_class_t           mem [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0]  wr_ptr_reg;
    logic [QPTR_BITS-1:0]  wr_ptr_next;
    logic [QPTR_BITS-1:0]  rd_ptr_reg;
    logic [QPTR_BITS-1:0]  rd_ptr_next;
    logic [QCNT_BITS-1:0]  count_reg;
    logic [QCNT_BITS-1:0]  count_next;

    assign full  = (count_reg == QCNT_BITS'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full && !pop))
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && empty))
        else $error("queue read while empty");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_BITS'(QUEUE_DEPTH))
        else $error("queue count out of range");
`endif

endmodule

// ----- rtl/nfs_back.sv -----
// ----------------------------------------------------------------------------
// nfs_back
// Conversion engine: skips whitespace, takes sign and digits, and issues a
// registered result when the field ends.
// ----------------------------------------------------------------------------
module nfs_back
    import nfs_pkg::*;
#(
    parameter int ACC_BITS = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  logic        queue_empty,
    input  char_class_t head,
    output logic        pop,
    output logic        res_valid,
    input  logic        res_stall,
    output result_t     res_item
);

    phase_t                phase_reg;
    phase_t                phase_next;
    logic [ACC_BITS-1:0]   acc_reg;
    logic [ACC_BITS-1:0]   acc_next;
    logic                  neg_reg;
    logic                  neg_next;
    logic                  taken_reg;
    logic                  taken_next;
    logic [14:0]           wl_reg;
    logic [14:0]           wl_next;
    logic                  res_valid_reg;
    logic                  res_valid_next;
    result_t               res_reg;
    result_t               res_next;

    logic                  start;
    logic [ACC_BITS-1:0]   base_acc;
    logic                  base_neg;
    logic                  base_taken;
    logic [14:0]           base_wl;
    logic [14:0]           wl_dec;
    logic [ACC_BITS-1:0]   scaled;
    logic [ACC_BITS-1:0]   step_acc;
    logic [ACC_BITS-1:0]   dig_ext;

    logic                  emit;
    logic                  fin_eof;
    logic                  fin_consumed;
    logic                  fin_taken;
    logic [ACC_BITS-1:0]   fin_acc;
    logic signed [ACC_BITS-1:0] fin_sacc;
    logic signed [63:0]    fin_wide;
    logic signed [31:0]    fin_value;

    assign pop       = !queue_empty && (!res_valid_reg || !res_stall);
    assign res_valid = res_valid_reg;
    assign res_item  = res_reg;

    assign start      = (phase_reg == PH_SKIP);
    assign base_acc   = start ? '0 : acc_reg;
    assign base_neg   = start ? 1'b0 : neg_reg;
    assign base_taken = start ? 1'b0 : taken_reg;
    assign base_wl    = start ? ((cfg.max_width == '0) ? DEFAULT_WIDTH : cfg.max_width)
                              : wl_reg;
    assign wl_dec     = base_wl - 15'd1;
    assign dig_ext    = ACC_BITS'(head.digit);

    always_comb
    begin
        if (cfg.base_mode == BASE_OCT)
        begin
            scaled = base_acc << 3;
        end
        else if (cfg.base_mode == BASE_HEX)
        begin
            scaled = base_acc << 4;
        end
        else
        begin
            scaled = (base_acc << 3) + (base_acc << 1);
        end
    end

    // Accumulate toward the signed value so no negation is needed at the end
    assign step_acc = base_neg ? (scaled - dig_ext) : (scaled + dig_ext);

    // Datapath and result decisions
    always_comb
    begin
        emit         = 1'b0;
        fin_eof      = 1'b0;
        fin_consumed = 1'b0;
        fin_taken    = base_taken;
        fin_acc      = base_acc;
        acc_next     = acc_reg;
        neg_next     = neg_reg;
        taken_next   = taken_reg;
        wl_next      = wl_reg;
        unique case (head.kind)
            KIND_END:
            begin
                emit    = 1'b1;
                fin_eof = 1'b1;
            end
            KIND_SPACE:
            begin
                emit = !start;
            end
            KIND_MINUS, KIND_PLUS:
            begin
                if (start)
                begin
                    acc_next   = '0;
                    neg_next   = (head.kind == KIND_MINUS);
                    taken_next = (head.kind == KIND_MINUS);
                    wl_next    = wl_dec;
                    fin_taken  = (head.kind == KIND_MINUS);
                    emit         = (wl_dec == '0);
                    fin_consumed = 1'b1;
                end
                else
                begin
                    emit = 1'b1;
                end
            end
            KIND_DIGIT:
            begin
                acc_next     = step_acc;
                neg_next     = base_neg;
                taken_next   = 1'b1;
                wl_next      = wl_dec;
                fin_acc      = step_acc;
                fin_taken    = 1'b1;
                emit         = (wl_dec == '0);
                fin_consumed = 1'b1;
            end
            KIND_OTHER:
            begin
                emit = 1'b1;
            end
            default:
            begin
                emit = 1'b1;
            end
        endcase
    end

    // Phase transitions
    always_comb
    begin
        phase_next = phase_reg;
        if (pop)
        begin
            if (emit)
            begin
                phase_next = PH_SKIP;
            end
            else if (start && head.kind == KIND_SPACE)
            begin
                phase_next = PH_SKIP;
            end
            else
            begin
                phase_next = PH_DIGITS;
            end
        end
    end

    assign fin_sacc = fin_acc;
    assign fin_wide = 64'(fin_sacc);

    always_comb
    begin
        if (cfg.result_size >= SIZE_LONG)
        begin
            fin_value = fin_wide[31:0];
        end
        else
        begin
            fin_value = 32'(signed'(fin_wide[15:0]));
        end
        res_next.value         = fin_taken ? fin_value : '0;
        res_next.assigned      = fin_taken;
        res_next.ended_by_eof  = fin_eof;
        res_next.char_consumed = fin_eof ? 1'b0 : fin_consumed;
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (pop && emit)
        begin
            res_valid_next = 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_SKIP;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && !emit)
        begin
            acc_reg   <= acc_next;
            neg_reg   <= neg_next;
            taken_reg <= taken_next;
            wl_reg    <= wl_next;
        end
        if (pop && emit)
        begin
            res_reg <= res_next;
        end
    end

`ifndef SYNTHESIS
    a_width_left: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DIGITS) |-> (wl_reg != '0))
        else $error("digit phase with no width left");

    a_eof_not_consumed: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_reg.ended_by_eof) |-> !res_reg.char_consumed)
        else $error("end of input marked as consumed");

    a_unassigned_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && !res_reg.assigned) |-> (res_reg.value == '0))
        else $error("unassigned result with nonzero value");
`endif

endmodule

// ----- rtl/numeric_field_scanner_core.sv -----
// ----------------------------------------------------------------------------
// numeric_field_scanner_core
// Converts a character stream into integer fields, scanf style.
//
//   channel | direction | handshake           | payload
//   in      | input     | in_valid / in_stall | in_item  (char_code, is_end)
//   res     | output    | res_valid/res_stall | res_item (value, assigned,
//           |           |                     |   ended_by_eof, char_consumed)
//   apb     | input     | psel/penable/pready | paddr, pwdata, prdata
//
// One character per cycle sustained while res_stall is low; the digit step
// (shift-add into the accumulator) is combinational in the back end.
// The character that ends the field passes through the queue; when the back
// end pops it, the result register is loaded and res_valid rises.
// A two-entry queue separates classification from conversion, so in_stall
// rises only once the queue fills behind a stalled result register.
// Reset clears the control state and loads the register defaults.
// ----------------------------------------------------------------------------
module numeric_field_scanner_core
    import nfs_pkg::*;
#(
    parameter int ACC_BITS = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  in_item_t    in_item,
    output logic        res_valid,
    input  logic        res_stall,
    output result_t     res_item
);

    logic [1:0]  base_mode_reg;
    logic [14:0] max_width_reg;
    logic [1:0]  result_size_reg;
    logic        cfg_write;
    cfg_t        cfg;

    logic        push;
    char_class_t push_data;
    char_class_t head;
    logic        pop;
    logic        queue_full;
    logic        queue_empty;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_mode_reg   <= BASE_MODE_RESET;
            max_width_reg   <= DEFAULT_WIDTH;
            result_size_reg <= RESULT_SIZE_RESET;
        end
        else if (cfg_write)
        begin
            unique case (paddr[3:2])
                REG_BASE_MODE:   base_mode_reg   <= pwdata[1:0];
                REG_MAX_WIDTH:   max_width_reg   <= pwdata[14:0];
                REG_RESULT_SIZE: result_size_reg <= pwdata[1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_BASE_MODE:   prdata = 32'(base_mode_reg);
            REG_MAX_WIDTH:   prdata = 32'(max_width_reg);
            REG_RESULT_SIZE: prdata = 32'(result_size_reg);
            default:         prdata = '0;
        endcase
    end

    assign cfg.base_mode   = base_mode_reg;
    assign cfg.max_width   = max_width_reg;
    assign cfg.result_size = result_size_reg;

    nfs_front u_front (
        .valid      (in_valid),
        .stall      (in_stall),
        .item       (in_item),
        .base_mode  (base_mode_reg),
        .queue_full (queue_full),
        .push       (push),
        .push_data  (push_data)
    );

    nfs_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .full      (queue_full),
        .empty     (queue_empty)
    );

    nfs_back #(
        .ACC_BITS (ACC_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .queue_empty (queue_empty),
        .head        (head),
        .pop         (pop),
        .res_valid   (res_valid),
        .res_stall   (res_stall),
        .res_item    (res_item)
    );

endmodule
